>>> rtl/qslerp_pkg.sv
`default_nettype none

package qslerp_pkg;

   localparam int DW    = 16;
   localparam int FB    = 14;
   localparam int IW    = 30;
   localparam int STEPS = 30;

   localparam int ST_DOT = 1;
   localparam int ST_COS = 2;
   localparam int ST_SQN = 3;
   localparam int SQ0    = 4;
   localparam int SQ_N   = 31;
   localparam int VEC0   = SQ0 + SQ_N;
   localparam int ST_MUL = VEC0 + STEPS;
   localparam int ROT0   = ST_MUL + 1;
   localparam int ST_DCK = ROT0 + STEPS;
   localparam int DIV0   = ST_DCK + 1;
   localparam int DIV_N  = 31;
   localparam int ST_PRD = DIV0 + DIV_N;
   localparam int ST_SUM = ST_PRD + 1;
   localparam int NST    = ST_SUM + 1;

   localparam logic [19:0]        COS_LIM  = 20'((9999 * (1 << FB)) / 10000);
   localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
   localparam logic [30:0]        IONE     = 31'h4000_0000;
   localparam logic [31:0]        K_MAX    = 32'h7FFF_FFFF;
   localparam logic [15:0]        ONE_F    = 16'h4000;

   typedef struct packed {
      logic [3:0][15:0] qa;
      logic [3:0][15:0] qb;
      logic [15:0]      blend;
      logic             pass_a;
      logic             pass_b;
      logic             neg;
      logic             lin;
      logic [3:0][17:0] dp;
      logic [19:0]      cosv;
      logic [29:0]      t30;
      logic [63:0]      sq_rem;
      logic [30:0]      sq_root;
      logic [33:0]      vx;
      logic [33:0]      vy;
      logic [33:0]      vz;
      logic [1:0][33:0] rx;
      logic [1:0][33:0] ry;
      logic [1:0][33:0] rz;
      logic [1:0]       wz;
      logic [1:0]       ws;
      logic [1:0][63:0] drem;
      logic [1:0][30:0] dq;
      logic [7:0][49:0] prod;
      logic [3:0][15:0] res;
   } stage_type;

   function automatic logic signed [33:0] arc_step(input int i);
      logic signed [33:0] v;
      case (i)
         0:       v = 34'sd843314857;
         1:       v = 34'sd497837829;
         2:       v = 34'sd263043837;
         3:       v = 34'sd133525159;
         4:       v = 34'sd67021687;
         5:       v = 34'sd33543516;
         6:       v = 34'sd16775851;
         7:       v = 34'sd8388437;
         8:       v = 34'sd4194283;
         9:       v = 34'sd2097149;
         default: v = 34'(64'd1 << (IW - i));
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/quaternion_slerp.sv
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while a result waits on rsp_tready.
// Depth is set by the bit-serial square root and divider and the two CORDIC
// chains, one step per stage.
// Reset clears all stage valid bits; the datapath registers are not reset.
`default_nettype none

module quaternion_slerp
   import qslerp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend
   input  wire logic [143:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_w, out_x, out_y, out_z
   output logic [63:0]       rsp_tdata
);

   stage_type        pipe_ff [NST];
   stage_type        pipe_in [NST];
   logic [NST-1:0]   vld_ff;
   logic             adv;

   assign adv        = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = pipe_ff[NST-1].res;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   for (genvar g = 0; g < NST; g++) begin : g_st
      if (g == 0) begin : g_in
         always_comb begin
            pipe_in[g] = '0;
            for (int l = 0; l < 4; l++) begin
               pipe_in[g].qa[l] = req_tdata[16*l +: 16];
               pipe_in[g].qb[l] = req_tdata[64 + 16*l +: 16];
            end
            pipe_in[g].blend  = req_tdata[143:128];
            pipe_in[g].pass_a = $signed(req_tdata[143:128]) <= 16'sd0;
            pipe_in[g].pass_b = $signed(req_tdata[143:128]) >= $signed(ONE_F);
         end
      end else if (g == ST_DOT) begin : g_dot
         logic signed [31:0] pr;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            pr = '0;
            for (int l = 0; l < 4; l++) begin
               pr = $signed(pipe_ff[g-1].qa[l]) * $signed(pipe_ff[g-1].qb[l]);
               pipe_in[g].dp[l] = 18'(pr >>> FB);
            end
         end
      end else if (g == ST_COS) begin : g_cos
         logic signed [19:0] csum;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            csum = $signed(pipe_ff[g-1].dp[0]) + $signed(pipe_ff[g-1].dp[1])
                 + $signed(pipe_ff[g-1].dp[2]) + $signed(pipe_ff[g-1].dp[3]);
            if (csum < 0) begin
               pipe_in[g].neg  = 1'b1;
               pipe_in[g].cosv = -csum;
            end else begin
               pipe_in[g].neg  = 1'b0;
               pipe_in[g].cosv = csum;
            end
            pipe_in[g].lin = pipe_in[g].cosv > COS_LIM;
            pipe_in[g].t30 = {pipe_ff[g-1].blend[13:0], 16'b0};
         end
      end else if (g == ST_SQN) begin : g_sqn
         logic [27:0] csq;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            csq = 28'(pipe_ff[g-1].cosv[13:0]) * 28'(pipe_ff[g-1].cosv[13:0]);
            pipe_in[g].sq_rem  = (64'd1 << 60) - {4'b0, csq, 32'b0};
            pipe_in[g].sq_root = '0;
         end
      end else if (g < VEC0) begin : g_sqrt
         localparam int K = 30 - (g - SQ0);
         logic [63:0] trial;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            trial = (64'(pipe_ff[g-1].sq_root) << (K + 1)) + (64'd1 << (2 * K));
            if (pipe_ff[g-1].sq_rem >= trial) begin
               pipe_in[g].sq_rem     = pipe_ff[g-1].sq_rem - trial;
               pipe_in[g].sq_root[K] = 1'b1;
            end
         end
      end else if (g < ST_MUL) begin : g_vec
         localparam int VI = g - VEC0;
         logic signed [33:0] x, y, z, dx, dy;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            if (VI == 0) begin
               x = $signed({4'b0, pipe_ff[g-1].cosv[13:0], 16'b0});
               y = $signed({3'b0, pipe_ff[g-1].sq_root});
               z = 34'sd0;
            end else begin
               x = $signed(pipe_ff[g-1].vx);
               y = $signed(pipe_ff[g-1].vy);
               z = $signed(pipe_ff[g-1].vz);
            end
            dx = x >>> VI;
            dy = y >>> VI;
            if (y > 0) begin
               x = x + dy;
               y = y - dx;
               z = z + arc_step(VI);
            end else begin
               x = x - dy;
               y = y + dx;
               z = z - arc_step(VI);
            end
            pipe_in[g].vx = x;
            pipe_in[g].vy = y;
            pipe_in[g].vz = z;
         end
      end else if (g == ST_MUL) begin : g_mul
         logic        [30:0] k0;
         logic signed [63:0] m0, m1;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            k0 = IONE - {1'b0, pipe_ff[g-1].t30};
            m0 = $signed({1'b0, k0}) * $signed(pipe_ff[g-1].vz[31:0]);
            m1 = $signed({2'b0, pipe_ff[g-1].t30}) * $signed(pipe_ff[g-1].vz[31:0]);
            pipe_in[g].rz[0] = 34'(m0 >>> IW);
            pipe_in[g].rz[1] = 34'(m1 >>> IW);
            pipe_in[g].rx[0] = GAIN_INV;
            pipe_in[g].rx[1] = GAIN_INV;
            pipe_in[g].ry    = '0;
         end
      end else if (g < ST_DCK) begin : g_rot
         localparam int RI = g - ROT0;
         logic signed [33:0] x, y, z, dx, dy;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            x = '0; y = '0; z = '0; dx = '0; dy = '0;
            for (int l = 0; l < 2; l++) begin
               x  = $signed(pipe_ff[g-1].rx[l]);
               y  = $signed(pipe_ff[g-1].ry[l]);
               z  = $signed(pipe_ff[g-1].rz[l]);
               dx = x >>> RI;
               dy = y >>> RI;
               if (z >= 0) begin
                  x = x - dy;
                  y = y + dx;
                  z = z - arc_step(RI);
               end else begin
                  x = x + dy;
                  y = y - dx;
                  z = z + arc_step(RI);
               end
               pipe_in[g].rx[l] = x;
               pipe_in[g].ry[l] = y;
               pipe_in[g].rz[l] = z;
            end
         end
      end else if (g == ST_DCK) begin : g_dck
         logic signed [33:0] sn;
         logic        [31:0] snc;
         logic        [63:0] num;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            sn = '0; snc = '0; num = '0;
            for (int l = 0; l < 2; l++) begin
               sn = $signed(pipe_ff[g-1].ry[l]);
               if (sn > 34'sd2147483648) begin
                  snc = 32'h8000_0000;
               end else begin
                  snc = sn[31:0];
               end
               num = {2'b0, snc, 30'b0};
               pipe_in[g].wz[l]   = sn <= 34'sd0;
               pipe_in[g].ws[l]   = num >= {2'b0, pipe_ff[g-1].sq_root, 31'b0};
               pipe_in[g].drem[l] = num;
               pipe_in[g].dq[l]   = '0;
            end
         end
      end else if (g < ST_PRD) begin : g_div
         localparam int K = 30 - (g - DIV0);
         logic [63:0] dsh;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            dsh = 64'(pipe_ff[g-1].sq_root) << K;
            for (int l = 0; l < 2; l++) begin
               if (pipe_ff[g-1].drem[l] >= dsh) begin
                  pipe_in[g].drem[l]  = pipe_ff[g-1].drem[l] - dsh;
                  pipe_in[g].dq[l][K] = 1'b1;
               end
            end
         end
      end else if (g == ST_PRD) begin : g_prd
         logic        [31:0] k0, k1;
         logic signed [16:0] bs;
         logic signed [49:0] pa, pb;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            if (pipe_ff[g-1].lin || pipe_ff[g-1].sq_root == '0) begin
               k0 = {1'b0, IONE - {1'b0, pipe_ff[g-1].t30}};
               k1 = {2'b0, pipe_ff[g-1].t30};
            end else begin
               k0 = pipe_ff[g-1].wz[0] ? 32'd0 :
                    pipe_ff[g-1].ws[0] ? K_MAX : {1'b0, pipe_ff[g-1].dq[0]};
               k1 = pipe_ff[g-1].wz[1] ? 32'd0 :
                    pipe_ff[g-1].ws[1] ? K_MAX : {1'b0, pipe_ff[g-1].dq[1]};
            end
            bs = '0; pa = '0; pb = '0;
            for (int l = 0; l < 4; l++) begin
               bs = $signed(pipe_ff[g-1].qb[l]);
               if (pipe_ff[g-1].neg) begin
                  bs = -bs;
               end
               pa = $signed({1'b0, k0}) * $signed(pipe_ff[g-1].qa[l]);
               pb = $signed({1'b0, k1}) * bs;
               pipe_in[g].prod[l]     = pa;
               pipe_in[g].prod[4 + l] = pb;
            end
         end
      end else begin : g_sum
         logic signed [50:0] acc;
         logic signed [20:0] r;
         always_comb begin
            pipe_in[g] = pipe_ff[g-1];
            acc = '0; r = '0;
            for (int l = 0; l < 4; l++) begin
               acc = $signed(pipe_ff[g-1].prod[l]) + $signed(pipe_ff[g-1].prod[4 + l])
                   + 51'sd536870912;
               r = 21'(acc >>> IW);
               if (pipe_ff[g-1].pass_a) begin
                  pipe_in[g].res[l] = pipe_ff[g-1].qa[l];
               end else if (pipe_ff[g-1].pass_b) begin
                  pipe_in[g].res[l] = pipe_ff[g-1].qb[l];
               end else if (r > 21'sd32767) begin
                  pipe_in[g].res[l] = 16'h7FFF;
               end else if (r < -21'sd32768) begin
                  pipe_in[g].res[l] = 16'h8000;
               end else begin
                  pipe_in[g].res[l] = r[15:0];
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/qslerp_chk.sv
`default_nettype none

module qslerp_chk (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid |-> !req_tready)
      else $error("input beat taken while pipeline holds");

endmodule

bind quaternion_slerp qslerp_chk u_chk (.*);

`default_nettype wire
